// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/smn_pkg.sv =====
// ----------------------------------------------------------------------------
// smn_pkg
// Types, constants and round functions for the SIMON 64/128 encrypt block.
// ----------------------------------------------------------------------------
`default_nettype none

package smn_pkg;

    localparam int ROUND_COUNT = 44;
    localparam int KEY_WORDS   = 4;
    localparam int WORD_W      = 32;
    localparam int RK_AW       = $clog2(ROUND_COUNT);
    localparam int CFG_IDX_W   = 8;

    localparam logic [63:0]       Z3_SEQ    = 64'hfc2c_e512_07a6_35db;
    localparam logic [WORD_W-1:0] KEY_CONST = 32'hffff_fffc;

    localparam logic [WORD_W-1:0] KEY_RST0 = 32'h0302_0100;
    localparam logic [WORD_W-1:0] KEY_RST1 = 32'h0b0a_0908;
    localparam logic [WORD_W-1:0] KEY_RST2 = 32'h1312_1110;
    localparam logic [WORD_W-1:0] KEY_RST3 = 32'h1b1a_1918;

    localparam logic [RK_AW-1:0] RK_LAST = RK_AW'(ROUND_COUNT - 1);

    typedef struct packed {
        logic [WORD_W-1:0] plain_upper;
        logic [WORD_W-1:0] plain_lower;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] cipher_upper;
        logic [WORD_W-1:0] cipher_lower;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic [RK_AW-1:0]  addr;
        logic [WORD_W-1:0] data;
    } t_rk_wr;

    typedef struct packed {
        logic             en;
        logic [RK_AW-1:0] addr;
    } t_rk_rd;

    typedef struct packed {
        logic busy;
    } t_exp_stat;

    typedef struct packed {
        logic busy;
    } t_core_stat;

    // One SIMON round: new x word.
    function automatic logic [WORD_W-1:0] f_round(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] y,
        input logic [WORD_W-1:0] k
    );
        logic [WORD_W-1:0] f;
        f = ({x[30:0], x[31]} & {x[23:0], x[31:24]}) ^ {x[29:0], x[31:30]};
        return f ^ y ^ k;
    endfunction

    // Next round key from the words one, three and four back.
    function automatic logic [WORD_W-1:0] f_key_next(
        input logic [WORD_W-1:0] k1,
        input logic [WORD_W-1:0] k3,
        input logic [WORD_W-1:0] k4,
        input logic              zbit
    );
        return KEY_CONST ^ {31'd0, zbit} ^ k4
            ^ {k1[2:0], k1[31:3]} ^ {k1[3:0], k1[31:4]}
            ^ k3 ^ {k3[0], k3[31:1]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/smn_rk_ram.sv =====
// ----------------------------------------------------------------------------
// smn_rk_ram
// Round key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smn_rk_ram
    import smn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_rk_wr            i_wr,
    input  wire t_rk_rd            i_rd,
    output logic [WORD_W-1:0]      o_rdata
);

    logic [WORD_W-1:0] r_mem [ROUND_COUNT];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/smn_key_sched.sv =====
// ----------------------------------------------------------------------------
// smn_key_sched
// Key registers and key expansion sequencer, one round key per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smn_key_sched
    import smn_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    output t_rk_wr                    o_wr,
    output t_exp_stat                 o_stat
);

    logic [WORD_W-1:0] r_key [KEY_WORDS];
    logic [WORD_W-1:0] r_win [KEY_WORDS];  // r_win[j] = key j+1 back
    logic              r_busy;
    logic [RK_AW-1:0]  r_idx;
    logic [RK_AW-1:0]  zidx;
    logic [WORD_W-1:0] kval;
    logic              key_wr;

    assign key_wr = i_cfg_valid && (i_cfg_index < CFG_IDX_W'(KEY_WORDS));
    assign zidx   = r_idx - RK_AW'(KEY_WORDS);

    always_comb begin
        if (r_idx < RK_AW'(KEY_WORDS)) begin
            kval = r_key[r_idx[1:0]];
        end else begin
            kval = f_key_next(r_win[0], r_win[2], r_win[3], Z3_SEQ[zidx]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= KEY_RST0;
            r_key[1] <= KEY_RST1;
            r_key[2] <= KEY_RST2;
            r_key[3] <= KEY_RST3;
            r_busy   <= 1'b1;
            r_idx    <= '0;
        end else if (key_wr) begin
            // restart expansion with the new key
            r_key[i_cfg_index[1:0]] <= i_cfg_data;
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == RK_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_win[0] <= kval;
            r_win[1] <= r_win[0];
            r_win[2] <= r_win[1];
            r_win[3] <= r_win[2];
        end
    end

    assign o_wr.en      = r_busy && !key_wr;
    assign o_wr.addr    = r_idx;
    assign o_wr.data    = kval;
    assign o_stat.busy  = r_busy;

endmodule

`default_nettype wire

// ===== hw/rtl/smn_round_core.sv =====
// ----------------------------------------------------------------------------
// smn_round_core
// Round datapath: one round per cycle on x/y bar stalls; round keys from RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module smn_round_core
    import smn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_in_item          i_item,
    input  wire logic [WORD_W-1:0] i_rk,
    output t_rk_rd                 o_rd,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_data,
    output t_core_stat             o_stat
);

    logic              r_busy;
    logic [RK_AW-1:0]  r_rnd;
    logic [WORD_W-1:0] r_x;
    logic [WORD_W-1:0] r_y;
    logic              r_out_valid;
    t_out_item         r_out_data;
    logic              last;
    logic              out_free;
    logic              step;
    logic [WORD_W-1:0] nx;

    assign last     = (r_rnd == RK_LAST);
    assign out_free = !r_out_valid || !i_out_stall;
    // hold the final round until the output register can take the item
    assign step     = r_busy && (!last || out_free);
    assign nx       = f_round(r_x, r_y, i_rk);

    always_comb begin
        o_rd.en   = i_start || (step && !last);
        o_rd.addr = i_start ? '0 : r_rnd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (step) begin
                r_rnd <= r_rnd + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (step && last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_item.plain_upper;
            r_y <= i_item.plain_lower;
        end else if (step) begin
            r_x <= nx;
            r_y <= r_x;
        end
        if (step && last) begin
            r_out_data.cipher_upper <= nx;
            r_out_data.cipher_lower <= r_x;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_stat.busy  = r_busy;

endmodule

`default_nettype wire

// ===== hw/rtl/simon64_128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// simon64_128_block_encrypt
// SIMON 64/128 encryption of one 64-bit block per item.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries plain_upper (x) and
// plain_lower (y); output channel o_out_valid / i_out_stall carries the
// ciphertext. An item moves when valid is high and stall is low.
// The four key words are written through i_cfg_valid / o_cfg_ready with a
// register index; indexes above three are ignored.
// The core runs one round per cycle over the 44 rounds; the first round key
// is read from the key store while the item loads. A new item is taken only
// once the previous item has finished its last round. After reset and after
// every key write the key schedule rewrites all 44 store entries, one per
// cycle; o_in_stall stays high until it is done.
// A stalled result waits in the output register; the next item may start
// meanwhile and holds in its last round until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module simon64_128_block_encrypt
    import smn_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    t_rk_wr            rk_wr;
    t_rk_rd            rk_rd;
    t_exp_stat         exp_stat;
    t_core_stat        core_stat;
    logic [WORD_W-1:0] rk;
    logic              start;
    logic              cfg_key_wr;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = exp_stat.busy || core_stat.busy;
    assign start       = i_in_valid && !o_in_stall;
    assign cfg_key_wr  = i_cfg_valid && o_cfg_ready && (i_cfg_index < CFG_IDX_W'(KEY_WORDS));

    smn_key_sched u_key_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_wr        (rk_wr),
        .o_stat      (exp_stat)
    );

    smn_rk_ram u_rk_ram (
        .i_clk   (i_clk),
        .i_wr    (rk_wr),
        .i_rd    (rk_rd),
        .o_rdata (rk)
    );

    smn_round_core u_round_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_in_data),
        .i_rk        (rk),
        .o_rd        (rk_rd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_stat      (core_stat)
    );

    `ASSERT_CLK(a_no_start_expand, i_clk, i_rst_n, start |-> !exp_stat.busy, "item in expansion")
    `ASSERT_CLK(a_start_sets_busy, i_clk, i_rst_n, start |=> core_stat.busy, "core not busy")
    `ASSERT_CLK(a_key_wr_expands, i_clk, i_rst_n, cfg_key_wr |=> exp_stat.busy, "no expansion")
    `ASSERT_ALWAYS(a_no_overlap, i_clk, !(i_rst_n && rk_wr.en && rk_rd.en), "key store clash")

endmodule

`default_nettype wire

// ===== verif/simon64_128_block_encrypt_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// simon64_128_block_encrypt_test
// Self-checking bench for the SIMON 64/128 block encrypt core. A scoreboard
// expands the key words into round keys and runs the 44 rounds to predict the
// ciphertext of every accepted plaintext. Short directed runs under the reset,
// all-zero and all-one keys come first, then random phases under fresh keys,
// all but one with random gaps and output back-pressure.
// ----------------------------------------------------------------------------
module simon64_128_block_encrypt_test;
    import smn_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        KEY_WORD0_IDX,
        KEY_WORD1_IDX,
        KEY_WORD2_IDX,
        KEY_WORD3_IDX
    } t_key_idx;

    localparam logic [CFG_IDX_W-1:0] IDX_ALL_ONES = '1;
    localparam bit   [63:0]          Z3_PATTERN   = 64'hfc2c_e512_07a6_35db;
    localparam bit   [31:0]          SCHED_CONST  = 32'hffff_fffc;
    localparam int                   Z3_PERIOD    = 62;
    localparam int                   RAND_PHASES  = 8;
    localparam int                   PHASE_ITEMS  = 94;
    localparam int                   CALM_PHASE   = 3;

    class cipher_scoreboard;
        bit [31:0] key_word[KEY_WORDS];
        bit [31:0] round_key[ROUND_COUNT];
        t_out_item pending_cipher[$];
        int        mismatch_count;

        function new();
            key_word = '{32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918};
            mismatch_count = 0;
            expand_round_keys();
        endfunction

        static function bit [31:0] rotl(bit [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        static function bit [31:0] rotr(bit [31:0] v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function void expand_round_keys();
            bit [31:0] k1;
            bit [31:0] k3;
            for (int i = 0; i < ROUND_COUNT; i++) begin
                if (i < KEY_WORDS) begin
                    round_key[i] = key_word[i];
                end else begin
                    k1 = round_key[i-1];
                    k3 = round_key[i-3];
                    round_key[i] = SCHED_CONST ^ 32'(Z3_PATTERN[(i - KEY_WORDS) % Z3_PERIOD])
                        ^ round_key[i-4] ^ rotr(k1, 3) ^ rotr(k1, 4) ^ k3 ^ rotr(k3, 1);
                end
            end
        endfunction

        // Out-of-range indexes leave the key untouched.
        function void load_key_word(logic [CFG_IDX_W-1:0] idx, bit [31:0] value);
            if (idx < KEY_WORDS) begin
                key_word[idx[1:0]] = value;
                expand_round_keys();
            end
        endfunction

        function t_out_item encrypt_block(t_in_item blk);
            bit [31:0] x;
            bit [31:0] y;
            bit [31:0] nx;
            t_out_item res;
            x = blk.plain_upper;
            y = blk.plain_lower;
            for (int r = 0; r < ROUND_COUNT; r++) begin
                nx = (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2) ^ y ^ round_key[r];
                y = x;
                x = nx;
            end
            res.cipher_upper = x;
            res.cipher_lower = y;
            return res;
        endfunction

        function void note_plaintext(t_in_item blk);
            pending_cipher.push_back(encrypt_block(blk));
        endfunction

        function void check_ciphertext(t_out_item got);
            t_out_item want;
            if (pending_cipher.size() == 0) begin
                $error("unexpected ciphertext %h_%h", got.cipher_upper, got.cipher_lower);
                mismatch_count++;
                return;
            end
            want = pending_cipher.pop_front();
            if (got.cipher_upper !== want.cipher_upper) begin
                $error("cipher_upper: expected %h, got %h", want.cipher_upper, got.cipher_upper);
                mismatch_count++;
            end
            if (got.cipher_lower !== want.cipher_lower) begin
                $error("cipher_lower: expected %h, got %h", want.cipher_lower, got.cipher_lower);
                mismatch_count++;
            end
        endfunction

        function int pending_count();
            return pending_cipher.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    cipher_scoreboard sb;
    bit               calm = 1'b0;

    simon64_128_block_encrypt u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Check each ciphertext as it leaves, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_ciphertext(o_out_data);
        end
        if (!calm && $urandom_range(99) < 10) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic bit [31:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return 32'h0000_0000;
        end else if (roll < 16) begin
            return 32'hffff_ffff;
        end
        return $urandom;
    endfunction

    // Leaves valid high unless a random gap follows, for back-to-back items.
    task automatic send_block(bit [31:0] upper, bit [31:0] lower);
        t_in_item blk;
        blk.plain_upper = upper;
        blk.plain_lower = lower;
        i_in_valid <= 1'b1;
        i_in_data  <= blk;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_plaintext(blk);
        if (!calm && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_key_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.load_key_word(idx, value);
    endtask

    task automatic write_all_keys(bit [31:0] value);
        write_key_reg(KEY_WORD0_IDX, value);
        write_key_reg(KEY_WORD1_IDX, value);
        write_key_reg(KEY_WORD2_IDX, value);
        write_key_reg(KEY_WORD3_IDX, value);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait for every ciphertext in flight.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    initial begin
        int mode;
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key: published vector, extremes, alternating and edge bits.
        send_block(32'h656b_696c, 32'h2064_6e75);
        send_block(32'h0000_0000, 32'h0000_0000);
        send_block(32'hffff_ffff, 32'hffff_ffff);
        send_block(32'hffff_ffff, 32'h0000_0000);
        send_block(32'h0000_0000, 32'hffff_ffff);
        send_block(32'h5555_5555, 32'haaaa_aaaa);
        send_block(32'haaaa_aaaa, 32'h5555_5555);
        send_block(32'h8000_0000, 32'h0000_0001);
        send_block(32'h0000_0001, 32'h8000_0000);
        drain();

        write_all_keys(32'h0000_0000);
        send_block(32'h0000_0000, 32'h0000_0000);
        send_block(32'hffff_ffff, 32'hffff_ffff);
        drain();

        write_all_keys(32'hffff_ffff);
        send_block(32'h0000_0000, 32'h0000_0000);
        send_block(32'hffff_ffff, 32'hffff_ffff);
        send_block(32'h656b_696c, 32'h2064_6e75);
        drain();

        // Indexes past the last key word must be ignored.
        write_key_reg(CFG_IDX_W'(KEY_WORDS), 32'h0000_0000);
        write_key_reg(IDX_ALL_ONES, 32'h0000_0000);
        write_key_reg(CFG_IDX_W'($urandom_range(KEY_WORDS, 254)), $urandom);
        i_cfg_valid <= 1'b0;
        send_block(32'h1234_5678, 32'h9abc_def0);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mode = $urandom_range(2);
            case (mode)
                0: begin
                    for (int k = 0; k < KEY_WORDS; k++) begin
                        write_key_reg(CFG_IDX_W'(k), pick_word());
                    end
                end
                1: begin
                    write_key_reg(CFG_IDX_W'($urandom_range(KEY_WORDS - 1)), pick_word());
                end
                default: begin
                    write_key_reg(CFG_IDX_W'($urandom_range(KEY_WORDS - 1)), 32'h0000_0000);
                    write_key_reg(CFG_IDX_W'($urandom_range(KEY_WORDS - 1)), 32'hffff_ffff);
                end
            endcase
            if ($urandom_range(99) < 30) begin
                write_key_reg(CFG_IDX_W'($urandom_range(KEY_WORDS, 255)), $urandom);
            end
            i_cfg_valid <= 1'b0;
            calm = (ph == CALM_PHASE);
            repeat (PHASE_ITEMS) send_block(pick_word(), pick_word());
            drain();
            calm = 1'b0;
        end

        repeat (60) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending_count() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/smn_pkg.sv
hw/rtl/smn_rk_ram.sv
hw/rtl/smn_key_sched.sv
hw/rtl/smn_round_core.sv
hw/rtl/simon64_128_block_encrypt.sv
verif/simon64_128_block_encrypt_test.sv
